FILE: src/ipsf_pkg.sv
// ----------------------------------------------------------------------------
// ipsf_pkg
// Shared constants and types for the interrupt picker with start-of-frame
// filter.
// ----------------------------------------------------------------------------
package ipsf_pkg;

  localparam int unsigned GPU_IRQ_COUNT   = 64;
  localparam int unsigned GPU_IRQ_OFFSET  = 8;
  localparam int unsigned USB_IRQ         = 17;
  localparam int unsigned TIMER_IRQ       = 0;
  localparam int unsigned SOF_PASS_PERIOD = 160;

  localparam int unsigned GPU_W   = 64;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned IRQ_W   = 7;
  localparam int unsigned FRAME_W = 14;
  localparam int unsigned CNT_W   = 8;

  localparam int unsigned FRAME_MAX  = 16'h3fff;
  localparam int unsigned FRAME_HALF = FRAME_MAX / 2;

  localparam int unsigned IN_DATA_W  = 96;
  localparam int unsigned OUT_DATA_W = 16;

  typedef struct packed {
    logic               timer_pending;
    logic [GPU_W-1:0]   gpu_pending;
    logic               sof_pending;
    logic               target_valid;
    logic               kick_flag;
    logic [FRAME_W-1:0] cur_frame;
    logic [FRAME_W-1:0] target_frame;
  } snap_t;

  typedef struct packed {
    logic             irq_taken;
    logic [IRQ_W-1:0] irq_number;
    logic             sof_ack;
    logic             cnt_upd;
    logic [CNT_W-1:0] cnt_nxt;
  } pick_t;

endpackage

FILE: src/ipsf_pick.sv
// ----------------------------------------------------------------------------
// ipsf_pick
// Fixed-priority irq selection and start-of-frame filter decision for one
// snapshot, given the current start-of-frame counter.
// ----------------------------------------------------------------------------
module ipsf_pick #(
  parameter int unsigned GPU_IRQ_COUNT   = ipsf_pkg::GPU_IRQ_COUNT,
  parameter int unsigned GPU_IRQ_OFFSET  = ipsf_pkg::GPU_IRQ_OFFSET,
  parameter int unsigned USB_IRQ         = ipsf_pkg::USB_IRQ,
  parameter int unsigned TIMER_IRQ       = ipsf_pkg::TIMER_IRQ,
  parameter int unsigned SOF_PASS_PERIOD = ipsf_pkg::SOF_PASS_PERIOD
) (
  input  ipsf_pkg::snap_t              snap,
  input  logic [ipsf_pkg::CNT_W-1:0]   sof_cnt,
  output ipsf_pkg::pick_t              pick
);
  import ipsf_pkg::*;

  logic               found;
  logic [IDX_W-1:0]   idx;
  logic [IRQ_W-1:0]   irq;
  logic               is_usb;
  logic [CNT_W-1:0]   cnt_inc;
  logic               period_hit;
  logic [FRAME_W-1:0] diff_th;
  logic [FRAME_W-1:0] diff_ht;
  logic               reached;
  logic               swallow;
  logic               filter_run;

  // lowest set bit among the first GPU_IRQ_COUNT bits
  always_comb begin
    found = 1'b0;
    idx   = '0;
    for (int i = GPU_W - 1; i >= 0; i--) begin
      if (i < GPU_IRQ_COUNT && snap.gpu_pending[i]) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
  end

  assign irq    = IRQ_W'(GPU_IRQ_OFFSET) + {1'b0, idx};
  assign is_usb = found && (irq == IRQ_W'(USB_IRQ));

  // wrap-aware frame compare
  assign diff_th = snap.target_frame - snap.cur_frame;
  assign diff_ht = snap.cur_frame - snap.target_frame;
  assign reached = (snap.cur_frame < snap.target_frame) ?
                   (diff_th >= FRAME_W'(FRAME_HALF)) :
                   (diff_ht <  FRAME_W'(FRAME_HALF));

  assign filter_run = !snap.timer_pending && is_usb && snap.sof_pending;
  assign cnt_inc    = sof_cnt + CNT_W'(1);
  assign period_hit = (cnt_inc == CNT_W'(SOF_PASS_PERIOD));
  assign swallow    = filter_run && !period_hit && snap.target_valid &&
                      !snap.kick_flag && !reached;

  always_comb begin
    pick.cnt_upd = filter_run;
    pick.cnt_nxt = period_hit ? '0 : cnt_inc;
    pick.sof_ack = swallow;
    if (snap.timer_pending) begin
      pick.irq_taken  = 1'b1;
      pick.irq_number = IRQ_W'(TIMER_IRQ);
    end else if (found && !swallow) begin
      pick.irq_taken  = 1'b1;
      pick.irq_number = irq;
    end else begin
      pick.irq_taken  = 1'b0;
      pick.irq_number = '0;
    end
  end

endmodule

FILE: src/irq_pick_with_sof_filter.sv
// ----------------------------------------------------------------------------
// irq_pick_with_sof_filter
// Picks the delivered interrupt from a pending snapshot (timer first, then
// lowest GPU bit) and swallows USB start-of-frame interrupts per the filter.
//
//   channel | dir | data                                   | handshake
//   in_     | in  | in_tdata   96 bits, one snapshot       | in_tvalid/in_tready
//   out_    | out | out_tdata  16 bits, one pick result    | out_tvalid/out_tready
//
// one request per cycle sustained while out_tready keeps the result moving; out_tvalid
// rises once the request has passed the input register, then the result register after the pick logic
// the start-of-frame counter updates when a request moves into the result
// register; reset clears it and both valid flags
// a stalled result holds; the input register still takes a request while
// it is empty or the result register is free or being drained
// ----------------------------------------------------------------------------
module irq_pick_with_sof_filter #(
  parameter int unsigned GPU_IRQ_COUNT   = ipsf_pkg::GPU_IRQ_COUNT,
  parameter int unsigned GPU_IRQ_OFFSET  = ipsf_pkg::GPU_IRQ_OFFSET,
  parameter int unsigned USB_IRQ         = ipsf_pkg::USB_IRQ,
  parameter int unsigned TIMER_IRQ       = ipsf_pkg::TIMER_IRQ,
  parameter int unsigned SOF_PASS_PERIOD = ipsf_pkg::SOF_PASS_PERIOD
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // timer_pending[0], gpu_pending_low[32:1], gpu_pending_high[64:33],
  // sof_pending[65], target_valid[66], kick_flag[67], cur_frame[81:68],
  // target_frame[95:82]
  input  logic [ipsf_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // irq_taken[0], irq_number[7:1], sof_ack[8], zero[15:9]
  output logic [ipsf_pkg::OUT_DATA_W-1:0]    out_tdata
);
  import ipsf_pkg::*;

  snap_t            snap_r;
  snap_t            snap_nxt;
  logic             s1_valid_r;
  logic             out_valid_r;
  pick_t            pick;
  logic             res_taken_r;
  logic [IRQ_W-1:0] res_number_r;
  logic             res_ack_r;
  logic [CNT_W-1:0] sof_cnt_r;
  logic             advance;
  logic             load;

  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || advance;
  assign load      = in_tvalid && in_tready;

  always_comb begin
    snap_nxt.timer_pending = in_tdata[0];
    snap_nxt.gpu_pending   = in_tdata[64:1];
    snap_nxt.sof_pending   = in_tdata[65];
    snap_nxt.target_valid  = in_tdata[66];
    snap_nxt.kick_flag     = in_tdata[67];
    snap_nxt.cur_frame     = in_tdata[81:68];
    snap_nxt.target_frame  = in_tdata[95:82];
  end

  ipsf_pick #(
    .GPU_IRQ_COUNT   (GPU_IRQ_COUNT),
    .GPU_IRQ_OFFSET  (GPU_IRQ_OFFSET),
    .USB_IRQ         (USB_IRQ),
    .TIMER_IRQ       (TIMER_IRQ),
    .SOF_PASS_PERIOD (SOF_PASS_PERIOD)
  ) u_pick (
    .snap    (snap_r),
    .sof_cnt (sof_cnt_r),
    .pick    (pick)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      sof_cnt_r   <= '0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= s1_valid_r;
        if (s1_valid_r && pick.cnt_upd) begin
          sof_cnt_r <= pick.cnt_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      snap_r <= snap_nxt;
    end
    if (advance && s1_valid_r) begin
      res_taken_r  <= pick.irq_taken;
      res_number_r <= pick.irq_number;
      res_ack_r    <= pick.sof_ack;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, res_ack_r, res_number_r, res_taken_r};

endmodule

FILE: tb/irq_pick_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// irq_pick_checker
// Watches both stream channels of the interrupt picker. Every accepted
// snapshot is run through a local model of the timer/GPU priority pick and
// the start-of-frame filter, with its own start-of-frame counter. Every
// accepted result is compared field by field with the oldest expected pick.
// ----------------------------------------------------------------------------
module irq_pick_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [ipsf_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [ipsf_pkg::OUT_DATA_W-1:0] out_tdata,
  output int                              mismatch_count,
  output int                              outstanding,
  output int                              result_count,
  output int                              swallowed_count,
  output int                              usb_taken_count
);
  import ipsf_pkg::*;

  typedef struct packed {
    logic             taken;
    logic [IRQ_W-1:0] number;
    logic             ack;
  } irq_pick_res_t;

  irq_pick_res_t    expected_picks[$];
  logic [CNT_W-1:0] sof_count;

  initial begin
    mismatch_count  = 0;
    outstanding     = 0;
    result_count    = 0;
    swallowed_count = 0;
    usb_taken_count = 0;
    sof_count       = '0;
  end

  function automatic snap_t unpack_snapshot(input logic [IN_DATA_W-1:0] d);
    snap_t s;
    s.timer_pending = d[0];
    s.gpu_pending   = {d[64:33], d[32:1]};
    s.sof_pending   = d[65];
    s.target_valid  = d[66];
    s.kick_flag     = d[67];
    s.cur_frame     = d[81:68];
    s.target_frame  = d[95:82];
    return s;
  endfunction

  function automatic bit frame_reached(input logic [FRAME_W-1:0] host,
                                       input logic [FRAME_W-1:0] target);
    int unsigned h;
    int unsigned t;
    h = 32'(host);
    t = 32'(target);
    if (h < t) return (t - h) >= FRAME_HALF;
    return (h - t) < FRAME_HALF;
  endfunction

  // advances the start-of-frame counter; 1 means the usb irq is swallowed
  function automatic bit sof_swallow(input snap_t s);
    if (!s.sof_pending) return 1'b0;
    sof_count = sof_count + 1'b1;
    if (sof_count == SOF_PASS_PERIOD) begin
      sof_count = '0;
      return 1'b0;
    end
    if (!s.target_valid || s.kick_flag) return 1'b0;
    if (frame_reached(s.cur_frame, s.target_frame)) return 1'b0;
    return 1'b1;
  endfunction

  function automatic irq_pick_res_t pick_irq(input snap_t s);
    irq_pick_res_t r;
    bit            found;
    int unsigned   irq;
    r     = '0;
    found = 1'b0;
    if (s.timer_pending) begin
      r.taken  = 1'b1;
      r.number = IRQ_W'(TIMER_IRQ);
    end else begin
      for (int i = 0; i < GPU_IRQ_COUNT; i++) begin
        if (!found && s.gpu_pending[i]) begin
          found = 1'b1;
          irq   = GPU_IRQ_OFFSET + i;
          if (irq == USB_IRQ && sof_swallow(s)) begin
            r.ack = 1'b1;
          end else begin
            r.taken  = 1'b1;
            r.number = IRQ_W'(irq);
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    irq_pick_res_t want;
    irq_pick_res_t got;
    if (!rst_n) begin
      sof_count = '0;
      expected_picks.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.taken  = out_tdata[0];
        got.number = out_tdata[7:1];
        got.ack    = out_tdata[8];
        result_count++;
        if (expected_picks.size() == 0) begin
          $error("result with no pending request: tdata %h", out_tdata);
          mismatch_count++;
        end else begin
          want = expected_picks.pop_front();
          if (got.taken !== want.taken) begin
            $error("irq_taken mismatch: expected %0d, got %0d", want.taken, got.taken);
            mismatch_count++;
          end
          if (got.number !== want.number) begin
            $error("irq_number mismatch: expected %0d, got %0d", want.number, got.number);
            mismatch_count++;
          end
          if (got.ack !== want.ack) begin
            $error("sof_ack mismatch: expected %0d, got %0d", want.ack, got.ack);
            mismatch_count++;
          end
          if (want.ack) swallowed_count++;
          if (want.taken && want.number == USB_IRQ) usb_taken_count++;
        end
      end
      if (in_tvalid && in_tready)
        expected_picks.push_back(pick_irq(unpack_snapshot(in_tdata)));
    end
    outstanding = expected_picks.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the interrupt picker with start-of-frame filter.
// A directed set covers the priority corners and the frame compare bounds,
// then random snapshots, mostly aimed at the usb irq with a start-of-frame
// pending, run through phases of sender idling and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import ipsf_pkg::*;

  localparam int      USB_BIT      = USB_IRQ - GPU_IRQ_OFFSET;
  localparam int      PHASE_ITEMS  = 375;
  localparam realtime RUN_LIMIT_NS = 2_000_000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;

  int mismatch_count;
  int outstanding;
  int result_count;
  int swallowed_count;
  int usb_taken_count;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int sent_count    = 0;
  int idle_tab[4]   = '{0, 51, 0, 24};
  int stall_tab[4]  = '{0, 0, 51, 24};

  always #5 clk = ~clk;

  irq_pick_with_sof_filter u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  irq_pick_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .mismatch_count  (mismatch_count),
    .outstanding     (outstanding),
    .result_count    (result_count),
    .swallowed_count (swallowed_count),
    .usb_taken_count (usb_taken_count)
  );

  always @(negedge clk) out_tready <= ($urandom_range(99) >= stall_pct);

  function automatic logic [IN_DATA_W-1:0] pack_snapshot(
    input logic               timer,
    input logic [31:0]        low,
    input logic [31:0]        high,
    input logic               sof,
    input logic               valid,
    input logic               kick,
    input logic [FRAME_W-1:0] host,
    input logic [FRAME_W-1:0] target
  );
    return {target, host, kick, valid, sof, high, low, timer};
  endfunction

  function automatic logic [FRAME_W-1:0] pick_target(input logic [FRAME_W-1:0] host);
    logic [FRAME_W-1:0] d;
    case ($urandom_range(2))
      0: d = FRAME_W'(FRAME_HALF + $urandom_range(4) - 2);
      1: d = FRAME_W'($urandom_range(3));
      default: d = FRAME_W'($urandom);
    endcase
    return $urandom_range(1) ? host + d : host - d;
  endfunction

  function automatic logic [IN_DATA_W-1:0] make_random_snapshot();
    logic [31:0]        low;
    logic [31:0]        high;
    logic [FRAME_W-1:0] host;
    int                 kind;
    kind = $urandom_range(99);
    host = FRAME_W'($urandom);
    high = $urandom;
    if (kind < 55) begin
      // usb irq mostly as the lowest pending bit, start-of-frame mostly set
      low = ($urandom & ~((32'd1 << (USB_BIT + 1)) - 1)) | (32'd1 << USB_BIT);
      if ($urandom_range(9) == 0) low[5'($urandom_range(USB_BIT - 1))] = 1'b1;
      return pack_snapshot($urandom_range(19) == 0, low, high,
                           $urandom_range(9) != 0, $urandom_range(7) != 0,
                           $urandom_range(7) == 0, host, pick_target(host));
    end
    if (kind < 75)
      return pack_snapshot(1'($urandom_range(1)), $urandom, high, 1'($urandom_range(1)),
                           1'($urandom_range(1)), 1'($urandom_range(1)), host,
                           FRAME_W'($urandom));
    if (kind < 90) begin
      low  = $urandom_range(1) ? 32'd1 << $urandom_range(31) : 32'd0;
      high = $urandom_range(1) ? 32'd1 << $urandom_range(31) : high;
      return pack_snapshot(1'b0, low, high, 1'($urandom_range(1)), 1'($urandom_range(1)),
                           1'($urandom_range(1)), host, pick_target(host));
    end
    return pack_snapshot(1'b0, 32'd0, $urandom_range(1) ? high : 32'd0,
                         1'($urandom_range(1)), 1'($urandom_range(1)),
                         1'($urandom_range(1)), host, FRAME_W'($urandom));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_snapshot(input logic [IN_DATA_W-1:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom, $urandom};
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
    @(negedge clk);
  endtask

  task automatic send_usb(input logic sof, input logic valid, input logic kick,
                          input logic [FRAME_W-1:0] host,
                          input logic [FRAME_W-1:0] target);
    send_snapshot(pack_snapshot(1'b0, 32'd1 << USB_BIT, 32'd0, sof, valid, kick,
                                host, target));
  endtask

  initial begin
    #(RUN_LIMIT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // priority corners
    send_snapshot(pack_snapshot(1'b0, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_snapshot(pack_snapshot(1'b1, '0, '0, 1'b0, 1'b0, 1'b0, '0, '0));
    send_snapshot(pack_snapshot(1'b1, '1, '1, 1'b1, 1'b1, 1'b1, '1, '1));
    send_snapshot(pack_snapshot(1'b0, '1, '1, 1'b1, 1'b1, 1'b0, '0, FRAME_W'(100)));
    send_snapshot(pack_snapshot(1'b0, '0, 32'h8000_0000, 1'b0, 1'b0, 1'b0, '0, '0));
    send_snapshot(pack_snapshot(1'b0, '0, 32'h0000_0001, 1'b1, 1'b1, 1'b0,
                                FRAME_W'(3), FRAME_W'(9)));
    // filter bypasses and frame compare bounds
    send_usb(1'b0, 1'b1, 1'b0, FRAME_W'(100), FRAME_W'(200));
    send_usb(1'b1, 1'b0, 1'b0, FRAME_W'(100), FRAME_W'(200));
    send_usb(1'b1, 1'b1, 1'b1, FRAME_W'(100), FRAME_W'(200));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(100), FRAME_W'(200));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(5), FRAME_W'(5));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(FRAME_HALF + 9), FRAME_W'(10));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(FRAME_HALF + 10), FRAME_W'(10));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(10), FRAME_W'(FRAME_HALF + 10));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(10), FRAME_W'(FRAME_HALF + 9));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(FRAME_MAX), '0);
    send_usb(1'b1, 1'b1, 1'b0, '0, FRAME_W'(FRAME_MAX));
    send_usb(1'b1, 1'b1, 1'b0, FRAME_W'(FRAME_MAX), FRAME_W'(FRAME_MAX));
    // lower gpu bit beats usb, usb with all high bits, timer beats usb
    send_snapshot(pack_snapshot(1'b0, (32'd1 << USB_BIT) | (32'd1 << (USB_BIT - 1)), 32'd0,
                                1'b1, 1'b1, 1'b0, FRAME_W'(100), FRAME_W'(200)));
    send_snapshot(pack_snapshot(1'b0, 32'hffff_ffff << USB_BIT, 32'hffff_ffff,
                                1'b1, 1'b1, 1'b0, FRAME_W'(100), FRAME_W'(200)));
    send_snapshot(pack_snapshot(1'b1, 32'd1 << USB_BIT, 32'd0, 1'b1, 1'b1, 1'b0,
                                FRAME_W'(100), FRAME_W'(200)));

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = idle_tab[p];
      stall_pct     = stall_tab[p];
      repeat (PHASE_ITEMS) send_snapshot(make_random_snapshot());
    end
    in_tvalid <= 1'b0;

    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("covered %0d snapshots over four idle/stall phases, %0d results checked",
             sent_count, result_count);
    $display("usb irq delivered %0d times, swallowed by the frame filter %0d times",
             usb_taken_count, swallowed_count);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
